// File: hw/rtl/pab_pkg.sv
// ----------------------------------------------------------------------------
// pab_pkg: shared types and constants of the packet access beat parser
// Beat layouts on both channels, result kind codes, command codes, parse
// phases and the sizing of the result queue.
// ----------------------------------------------------------------------------
package pab_pkg;

  // Input beat: one packet byte and its end-of-packet flag.
  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       end_of_packet;
  } in_beat_t;

  // Output beat: one result.
  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] access_addr;
    logic [31:0] access_data;
    logic [63:0] txn_id;
    logic        last_of_run;
  } result_t;

  // Results produced by one input byte, in order, handed to the queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } push_t;

  // Result kinds.
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_BAD_CMD = 3'd3;
  localparam logic [2:0] KIND_BAD_REP = 3'd4;
  localparam logic [2:0] KIND_TRUNC   = 3'd5;

  // Command byte codes.
  localparam logic [7:0] CMD_WRITE      = 8'h00;
  localparam logic [7:0] CMD_READ       = 8'h10;
  localparam logic [7:0] CMD_BURST      = 8'h20;
  localparam logic [7:0] CMD_CHECK_MASK = 8'hcf;

  // Last byte index of each field (id, repeat count, address, data).
  localparam logic [2:0] ID_LAST   = 3'd7;
  localparam logic [2:0] REP_LAST  = 3'd2;
  localparam logic [2:0] ADDR_LAST = 3'd2;
  localparam logic [2:0] DATA_LAST = 3'd3;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_ID    = 3'd0,
    PH_CMD   = 3'd1,
    PH_REP   = 3'd2,
    PH_INNER = 3'd3,
    PH_ADDR  = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  // Result queue sizing.
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);

endpackage

// File: hw/rtl/pab_parse.sv
// ----------------------------------------------------------------------------
// pab_parse: packet parse state machine
// Holds the parse state and turns each accepted byte into zero, one or two
// results in the same cycle.
// ----------------------------------------------------------------------------
module pab_parse #(
  parameter int unsigned MAX_REPEAT = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  pab_pkg::in_beat_t in_data,
  input  logic              check_enable,
  output pab_pkg::push_t    push
);
  import pab_pkg::*;

  phase_e      phase, phase_next;
  logic [2:0]  cnt, cnt_next;
  logic [63:0] id, id_next;
  logic [7:0]  cmd, cmd_next;
  logic [23:0] addr, addr_next;
  logic [31:0] data, data_next;
  logic [23:0] rep, rep_next;
  logic        in_burst, in_burst_next;
  logic        dropping, dropping_next;

  logic        eop;
  logic [7:0]  b;
  logic        boundary;
  logic        err_hit;
  logic [2:0]  err_kind;
  logic        acc_hit;
  logic [2:0]  acc_kind;
  logic        quiet;
  logic        final_hit;
  logic        clear;
  logic        cmd_bad;
  logic [23:0] rep_dec;
  result_t     acc_res;
  result_t     fin_res;

  assign eop = in_data.end_of_packet;
  assign b   = in_data.pkt_byte;
  assign cmd_bad = check_enable && ((b & CMD_CHECK_MASK) != 8'h00);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_ID;
      cnt      <= '0;
      id       <= '0;
      cmd      <= '0;
      addr     <= '0;
      data     <= '0;
      rep      <= '0;
      in_burst <= 1'b0;
      dropping <= 1'b0;
    end else begin
      phase    <= phase_next;
      cnt      <= cnt_next;
      id       <= id_next;
      cmd      <= cmd_next;
      addr     <= addr_next;
      data     <= data_next;
      rep      <= rep_next;
      in_burst <= in_burst_next;
      dropping <= dropping_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    cnt_next      = cnt;
    id_next       = id;
    cmd_next      = cmd;
    addr_next     = addr;
    data_next     = data;
    rep_next      = rep;
    in_burst_next = in_burst;
    dropping_next = dropping;
    boundary      = 1'b0;
    err_hit       = 1'b0;
    err_kind      = KIND_BAD_CMD;
    acc_hit       = 1'b0;
    acc_kind      = KIND_WRITE;
    quiet         = 1'b0;
    clear         = 1'b0;
    rep_dec       = rep;

    if (accept) begin
      if (dropping) begin
        // Skip the rest of a failed packet.
        quiet = 1'b1;
        clear = eop;
      end else begin
        unique case (phase)
          PH_ID: begin
            id_next  = {id[55:0], b};
            cnt_next = cnt + 3'd1;
            if (cnt == ID_LAST) begin
              cnt_next   = '0;
              phase_next = PH_CMD;
              boundary   = 1'b1;
            end
          end
          PH_CMD: begin
            if (eop) begin
              boundary = 1'b1;
            end else begin
              cmd_next = b;
              cnt_next = '0;
              if (cmd_bad) begin
                err_hit = 1'b1;
              end else if (b == CMD_BURST) begin
                in_burst_next = 1'b1;
                rep_next      = '0;
                phase_next    = PH_REP;
              end else begin
                in_burst_next = 1'b0;
                phase_next    = PH_ADDR;
              end
            end
          end
          PH_REP: begin
            rep_next = {rep[15:0], b};
            cnt_next = cnt + 3'd1;
            if (cnt == REP_LAST) begin
              cnt_next   = '0;
              phase_next = PH_INNER;
            end
          end
          PH_INNER: begin
            cmd_next = b;
            if (cmd_bad) begin
              err_hit = 1'b1;
            end else if (check_enable && (rep > 24'(MAX_REPEAT))) begin
              err_hit  = 1'b1;
              err_kind = KIND_BAD_REP;
            end else begin
              phase_next = PH_ADDR;
            end
          end
          PH_ADDR: begin
            addr_next = {addr[15:0], b};
            cnt_next  = cnt + 3'd1;
            if (cnt == ADDR_LAST) begin
              cnt_next = '0;
              if (in_burst && (rep == 24'd0)) begin
                in_burst_next = 1'b0;
                phase_next    = PH_CMD;
                boundary      = 1'b1;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            data_next = {data[23:0], b};
            cnt_next  = cnt + 3'd1;
            if (cnt == DATA_LAST) begin
              cnt_next = '0;
              if (cmd == CMD_WRITE) begin
                acc_hit  = 1'b1;
                acc_kind = KIND_WRITE;
              end else if (cmd == CMD_READ) begin
                acc_hit  = 1'b1;
                acc_kind = KIND_READ;
              end
              if (in_burst) begin
                rep_dec = rep - 24'd1;
              end
              rep_next = rep_dec;
              if (!in_burst || (rep_dec == 24'd0)) begin
                in_burst_next = 1'b0;
                phase_next    = PH_CMD;
                boundary      = 1'b1;
              end
            end
          end
          default: begin
            // Unreachable code: drop the byte and restart.
            quiet = 1'b1;
            clear = 1'b1;
          end
        endcase

        if (!quiet) begin
          if (err_hit) begin
            if (eop) begin
              clear = 1'b1;
            end else begin
              dropping_next = 1'b1;
            end
          end else if (eop) begin
            clear = 1'b1;
          end
        end
      end
    end

    final_hit = accept && !quiet && (err_hit || eop);

    acc_res.kind        = acc_kind;
    acc_res.access_addr = addr;
    acc_res.access_data = data_next;
    acc_res.txn_id      = id_next;
    acc_res.last_of_run = !final_hit;

    fin_res.kind        = err_hit ? err_kind : (boundary ? KIND_DONE : KIND_TRUNC);
    fin_res.access_addr = '0;
    fin_res.access_data = '0;
    fin_res.txn_id      = id_next;
    fin_res.last_of_run = 1'b1;

    push.slot1 = fin_res;
    if (acc_hit && final_hit) begin
      push.count = 2'd2;
      push.slot0 = acc_res;
    end else if (acc_hit) begin
      push.count = 2'd1;
      push.slot0 = acc_res;
    end else if (final_hit) begin
      push.count = 2'd1;
      push.slot0 = fin_res;
    end else begin
      push.count = 2'd0;
      push.slot0 = acc_res;
    end

    if (clear) begin
      phase_next    = PH_ID;
      cnt_next      = '0;
      id_next       = '0;
      cmd_next      = '0;
      addr_next     = '0;
      data_next     = '0;
      rep_next      = '0;
      in_burst_next = 1'b0;
      dropping_next = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && dropping) |-> (push.count == 2'd0))
    else $error("result produced while dropping a failed packet");

  a_eop_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && eop) |=> ((phase == PH_ID) && !dropping && (cnt == 3'd0)))
    else $error("parser not back at transaction id after end of packet");

  a_two_only_at_eop: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (accept && eop && (phase == PH_DATA)))
    else $error("two results from a byte that is not a final data byte");
`endif

endmodule

// File: hw/rtl/pab_outq.sv
// ----------------------------------------------------------------------------
// pab_outq: result queue
// Small register queue: takes up to two results per cycle from the parser
// while two fit, hands one per cycle to the output channel when not stalled.
// ----------------------------------------------------------------------------
module pab_outq (
  input  logic             clk,
  input  logic             rst,
  input  pab_pkg::push_t   push,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output pab_pkg::result_t out_data
);
  import pab_pkg::*;

  result_t              entries [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [OUTQ_AW-1:0]   wr_ptr_inc;
  logic [OUTQ_AW:0]     count, count_next;
  logic                 pop;

  assign pop        = out_valid && !out_stall;
  assign wr_ptr_inc = wr_ptr + OUTQ_AW'(1);
  assign out_valid  = (count != '0);
  assign out_data   = entries[rd_ptr];
  // Hold the input off unless two results still fit.
  assign full       = (count > (OUTQ_AW + 1)'(OUTQ_DEPTH - 2));

  assign count_next = count + (OUTQ_AW + 1)'(push.count) - (OUTQ_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_AW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_inc] <= push.slot1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= (OUTQ_AW + 1)'(OUTQ_DEPTH - 2)))
    else $error("results pushed into a queue without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    count <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
    else $error("queue count beyond depth");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");
`endif

endmodule

// File: hw/rtl/packet_access_beat_parser.sv
// ----------------------------------------------------------------------------
// packet_access_beat_parser: packet byte parser issuing read/write requests
// Collects the transaction id, decodes plain and burst beats, and reports
// accesses, errors and end of packet as result beats.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle while in_stall is low, back to
// back, with no gaps required between packets. Each accepted byte is decoded
// in the cycle it arrives: the parse state registers update at that edge and
// any results land in a four-entry result queue at that edge, reaching the
// output behind older ones. A byte causes at most two results (an access
// and a done/truncated report when a data word completes on the final byte);
// everything else yields zero or one, so the queue drains as fast as it fills
// while the output side keeps up. in_stall rises when fewer than two queue
// entries are free, which happens only under output back-pressure. The
// check_enable register powers up set and should be written only while no
// packet is in progress; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module packet_access_beat_parser #(
  parameter int unsigned MAX_REPEAT = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pab_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pab_pkg::result_t  out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import pab_pkg::*;

  logic  check_enable;
  logic  accept;
  logic  q_full;
  push_t push;

  // Take a beat whenever the queue can absorb its worst case.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Checking register: set out of reset, written directly by the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b1;
    end else if (cfg_we) begin
      check_enable <= cfg_wdata;
    end
  end

  // Decode each accepted byte against the running parse state.
  pab_parse #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_data      (in_data),
    .check_enable (check_enable),
    .push         (push)
  );

  // Buffer results so the input never waits on a single stalled result.
  pab_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_packet_access_beat_parser.sv
// ----------------------------------------------------------------------------
// tb_packet_access_beat_parser: self-checking bench for the beat parser
// Feeds packets byte by byte through the valid/stall input channel, predicts
// every read, write, done, error and truncation result in the bench, and
// compares each accepted result beat field by field. Covers both settings of
// check_enable under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_packet_access_beat_parser;
  import pab_pkg::*;

  localparam int unsigned REPEAT_LIMIT = 31;
  localparam int MISMATCH_REPORTS = 10;
  localparam int PHASE_BYTES = 24;      // minimum random bytes per phase, 8 phases
  localparam int DRAIN_CYCLES = 8;      // settling time after the last result is out
  localparam int RUN_LIMIT = 2000000;   // time units, far past the slowest run
  localparam logic [7:0] CMD_SILENT = 8'h30;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_beat_t in_data;
  logic     out_valid;
  logic     out_stall;
  result_t  out_data;
  logic     cfg_we;
  logic     cfg_wdata;

  packet_access_beat_parser #(
    .MAX_REPEAT(REPEAT_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser shadow state, advanced once per accepted input beat.
  // --------------------------------------------------------------------------
  logic        chk_en;
  phase_e      phase;
  int unsigned field_count;
  logic [63:0] id_sr;
  logic [7:0]  beat_cmd;
  logic [23:0] addr_sr;
  logic [31:0] data_sr;
  logic [23:0] reps_left;
  logic        burst_on;
  logic        dropping;

  in_beat_t    pending_beats[$];     // bytes waiting to be driven
  result_t     awaited_results[$];   // predicted results, oldest first
  logic [7:0]  pkt_bytes[$];         // packet under construction

  int send_idle_pct;
  int recv_stall_pct;
  int queued_bytes;
  int accepted_bytes;
  int packets_queued;
  int mismatches;
  int accesses_seen;
  int errors_seen;
  int reports_seen;

  task automatic clear_parse();
    phase       = PH_ID;
    field_count = 0;
    id_sr       = '0;
    beat_cmd    = '0;
    addr_sr     = '0;
    data_sr     = '0;
    reps_left   = '0;
    burst_on    = 1'b0;
    dropping    = 1'b0;
  endtask

  function automatic result_t make_result(input logic [2:0] kind, input logic [23:0] addr,
                                          input logic [31:0] data);
    result_t r;
    r.kind        = kind;
    r.access_addr = addr;
    r.access_data = data;
    r.txn_id      = id_sr;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Advance the shadow parser by one byte and queue the results it causes.
  task automatic parse_packet_byte(input in_beat_t beat);
    result_t    res[2];
    int         n;
    logic       at_boundary;
    logic       have_err;
    logic [2:0] err_kind;
    logic [7:0] b;
    logic       eop;
    n           = 0;
    at_boundary = 1'b0;
    have_err    = 1'b0;
    err_kind    = KIND_BAD_CMD;
    b           = beat.pkt_byte;
    eop         = beat.end_of_packet;

    // After an error, swallow bytes up to the end of the packet.
    if (dropping) begin
      if (eop) clear_parse();
      return;
    end

    case (phase)
      PH_ID: begin
        id_sr = {id_sr[55:0], b};
        field_count++;
        if (field_count >= 8) begin
          field_count = 0;
          phase       = PH_CMD;
          at_boundary = 1'b1;
        end
      end
      PH_CMD: begin
        // A final byte where a beat would start is ignored unchecked.
        if (eop) begin
          at_boundary = 1'b1;
        end else begin
          beat_cmd    = b;
          field_count = 0;
          if (chk_en && (b & CMD_CHECK_MASK) != 8'h00) begin
            have_err = 1'b1;
            err_kind = KIND_BAD_CMD;
          end else if (b == CMD_BURST) begin
            burst_on  = 1'b1;
            reps_left = '0;
            phase     = PH_REP;
          end else begin
            burst_on = 1'b0;
            phase    = PH_ADDR;
          end
        end
      end
      PH_REP: begin
        reps_left = {reps_left[15:0], b};
        field_count++;
        if (field_count >= 3) begin
          field_count = 0;
          phase       = PH_INNER;
        end
      end
      PH_INNER: begin
        // Inner command goes first, then the repeat count limit.
        beat_cmd = b;
        if (chk_en && (b & CMD_CHECK_MASK) != 8'h00) begin
          have_err = 1'b1;
          err_kind = KIND_BAD_CMD;
        end else if (chk_en && reps_left > 24'(REPEAT_LIMIT)) begin
          have_err = 1'b1;
          err_kind = KIND_BAD_REP;
        end else begin
          phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        addr_sr = {addr_sr[15:0], b};
        field_count++;
        if (field_count >= 3) begin
          field_count = 0;
          if (burst_on && reps_left == 0) begin
            burst_on    = 1'b0;
            phase       = PH_CMD;
            at_boundary = 1'b1;
          end else begin
            phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        data_sr = {data_sr[23:0], b};
        field_count++;
        if (field_count >= 4) begin
          field_count = 0;
          if (beat_cmd == CMD_WRITE) begin
            res[n] = make_result(KIND_WRITE, addr_sr, data_sr);
            n++;
          end else if (beat_cmd == CMD_READ) begin
            res[n] = make_result(KIND_READ, addr_sr, data_sr);
            n++;
          end
          // Burst words reuse the same address; only the count moves.
          if (burst_on) reps_left = reps_left - 24'd1;
          if (!burst_on || reps_left == 0) begin
            burst_on    = 1'b0;
            phase       = PH_CMD;
            at_boundary = 1'b1;
          end
        end
      end
      default: begin
        clear_parse();
        return;
      end
    endcase

    if (have_err) begin
      res[n] = make_result(err_kind, '0, '0);
      n++;
      if (eop) clear_parse();
      else dropping = 1'b1;
    end else if (eop) begin
      res[n] = make_result(at_boundary ? KIND_DONE : KIND_TRUNC, '0, '0);
      n++;
      clear_parse();
    end

    if (n > 0) res[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) awaited_results.push_back(res[i]);
  endtask

  // --------------------------------------------------------------------------
  // Packet building helpers.
  // --------------------------------------------------------------------------
  // Append a field most significant byte first.
  task automatic add_field(input logic [63:0] value, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) pkt_bytes.push_back(value[8*i +: 8]);
  endtask

  // Hand the packet to the driver, flagging its final byte.
  task automatic queue_packet();
    in_beat_t beat;
    foreach (pkt_bytes[i]) begin
      beat.pkt_byte      = pkt_bytes[i];
      beat.end_of_packet = (i == pkt_bytes.size() - 1);
      pending_beats.push_back(beat);
    end
    queued_bytes += pkt_bytes.size();
    packets_queued++;
    pkt_bytes.delete();
  endtask

  // Wait until every byte is in and every result is out, then let the block settle.
  task automatic wait_idle();
    while (accepted_bytes != queued_bytes || awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the register only with no packet in flight; mirror it in the shadow.
  task automatic write_check_enable(input logic en);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chk_en     = en;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: hold a stalled beat, advance on acceptance, idle at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_packet_byte(in_data);
        accepted_bytes++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
        end else begin
          // Put junk on the bus while idle; it must be ignored.
          in_valid <= 1'b0;
          in_data  <= in_beat_t'(9'($urandom));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MISMATCH_REPORTS)
            $display("unexpected result: kind=%0d addr=%06h data=%08h id=%016h last=%0b",
                     out_data.kind, out_data.access_addr, out_data.access_data,
                     out_data.txn_id, out_data.last_of_run);
        end else begin
          want = awaited_results.pop_front();
          if (want.kind inside {KIND_READ, KIND_WRITE}) accesses_seen++;
          else if (want.kind inside {KIND_BAD_CMD, KIND_BAD_REP}) errors_seen++;
          else reports_seen++;
          if (out_data.kind !== want.kind || out_data.access_addr !== want.access_addr ||
              out_data.access_data !== want.access_data ||
              out_data.txn_id !== want.txn_id ||
              out_data.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORTS) begin
              $display("result mismatch, expected: kind=%0d addr=%06h data=%08h id=%016h last=%0b",
                       want.kind, want.access_addr, want.access_data,
                       want.txn_id, want.last_of_run);
              $display("                 actual:   kind=%0d addr=%06h data=%08h id=%016h last=%0b",
                       out_data.kind, out_data.access_addr, out_data.access_data,
                       out_data.txn_id, out_data.last_of_run);
            end
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed packets, then random packets over eight phases.
  // --------------------------------------------------------------------------
  initial begin
    int          phase_bytes;
    int          n_beats;
    int          sel;
    int          words;
    int          keep;
    logic        stop;
    logic [23:0] count;
    logic [7:0]  cmd;

    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queued_bytes   = 0;
    accepted_bytes = 0;
    packets_queued = 0;
    mismatches     = 0;
    accesses_seen  = 0;
    errors_seen    = 0;
    reports_seen   = 0;
    chk_en         = 1'b1;
    clear_parse();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // All-ones id and write, all-zero read, silent command, lone trailing byte.
    add_field(64'hffff_ffff_ffff_ffff, 8);
    add_field(CMD_WRITE, 1); add_field(24'hff_ffff, 3); add_field(32'hffff_ffff, 4);
    add_field(CMD_READ, 1);  add_field(24'h0, 3);       add_field(32'h0, 4);
    add_field(CMD_SILENT, 1); add_field(24'h12_3456, 3); add_field(32'h89ab_cdef, 4);
    add_field(8'hff, 1);
    queue_packet();
    // Packet that ends inside the id: partial id comes back with truncated.
    add_field(24'haa_550f, 3);
    queue_packet();
    // Nested burst consumed silently, then a one-word read burst ending the packet.
    add_field(64'h0, 8);
    add_field(CMD_BURST, 1); add_field(24'd2, 3); add_field(CMD_BURST, 1);
    add_field(24'h00_0100, 3); add_field(32'h1111_2222, 4); add_field(32'h3333_4444, 4);
    add_field(CMD_BURST, 1); add_field(24'd1, 3); add_field(CMD_READ, 1);
    add_field(24'h80_0001, 3); add_field(32'h5555_6666, 4);
    queue_packet();
    // Bad inner command together with a bad count: the command wins; drop the rest.
    add_field(64'h0123_4567_89ab_cdef, 8);
    add_field(CMD_BURST, 1); add_field(24'h00_0040, 3); add_field(8'h01, 1);
    add_field(24'h77_7777, 3);
    queue_packet();
    // Count just over the limit, error on the final byte.
    add_field(64'hfedc_ba98_7654_3210, 8);
    add_field(CMD_BURST, 1); add_field(24'(REPEAT_LIMIT + 1), 3); add_field(CMD_WRITE, 1);
    queue_packet();
    // Access stands, then a bad beat command aborts the packet.
    add_field(64'h5a5a_a5a5_0f0f_f0f0, 8);
    add_field(CMD_WRITE, 1); add_field(24'h00_1234, 3); add_field(32'hdead_beef, 4);
    add_field(8'hc0, 1); add_field(16'h0102, 2);
    queue_packet();
    // Packet ending inside a data word.
    add_field(64'h0000_0001_0000_0002, 8);
    add_field(CMD_READ, 1); add_field(24'h44_4444, 3); add_field(16'hbeef, 2);
    queue_packet();

    for (int mode = 0; mode < 4; mode++) begin
      for (int en = 1; en >= 0; en--) begin
        write_check_enable(1'(en));
        // No idling, sender idle, receiver stalling, then a light mix of both.
        send_idle_pct  = (mode == 1) ? 69 : (mode == 3) ? 10 : 0;
        recv_stall_pct = (mode == 2) ? 69 : (mode == 3) ? 10 : 0;
        phase_bytes    = 0;
        while (phase_bytes < PHASE_BYTES) begin
          add_field({$urandom, $urandom}, 8);
          stop    = 1'b0;
          n_beats = $urandom_range(0, 4);
          for (int i = 0; i < n_beats && !stop; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
              add_field(CMD_WRITE, 1); add_field($urandom, 3); add_field($urandom, 4);
            end else if (sel < 55) begin
              add_field(CMD_READ, 1); add_field($urandom, 3); add_field($urandom, 4);
            end else if (sel < 62) begin
              add_field(CMD_SILENT, 1); add_field($urandom, 3); add_field($urandom, 4);
            end else if (sel < 85) begin
              sel = $urandom_range(0, 9);
              if (sel == 0) count = '0;
              else if (sel == 1) count = 24'(REPEAT_LIMIT);
              else if (sel == 2) count = 24'(REPEAT_LIMIT + 1);
              else if (sel == 3) count = 24'($urandom);
              else count = 24'($urandom_range(1, 3));
              sel = $urandom_range(0, 9);
              if (sel < 4) cmd = CMD_WRITE;
              else if (sel < 7) cmd = CMD_READ;
              else if (sel == 7) cmd = CMD_BURST;
              else if (sel == 8) cmd = CMD_SILENT;
              else cmd = 8'($urandom);
              add_field(CMD_BURST, 1); add_field(count, 3);
              add_field(cmd, 1); add_field($urandom, 3);
              // Long bursts get cut short, which ends the packet mid-burst.
              if (count <= 6) begin
                words = count;
              end else begin
                words = $urandom_range(0, 3);
                stop  = 1'b1;
              end
              repeat (words) add_field($urandom, 4);
            end else if (sel < 93) begin
              cmd = 8'($urandom);
              if ((cmd & CMD_CHECK_MASK) == 8'h00) cmd = cmd | 8'h80;
              add_field(cmd, 1); add_field($urandom, 3); add_field($urandom, 4);
            end else begin
              repeat ($urandom_range(1, 12)) add_field($urandom_range(0, 255), 1);
            end
          end
          // Most packets end cleanly; some carry a lone trailing byte, some are cut.
          sel = $urandom_range(0, 99);
          if (sel < 15) begin
            add_field($urandom_range(0, 255), 1);
          end else if (sel < 35) begin
            keep = $urandom_range(1, pkt_bytes.size() - 1);
            while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
          end
          phase_bytes += pkt_bytes.size();
          queue_packet();
        end
      end
    end

    wait_idle();
    $display("Drove %0d bytes in %0d packets; checked %0d accesses, %0d errors, %0d done/truncated",
             accepted_bytes, packets_queued, accesses_seen, errors_seen, reports_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d result mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard: a missing result stalls the drain wait forever.
  initial begin
    #(RUN_LIMIT);
    $display("Timed out with %0d results outstanding", awaited_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pab_pkg.sv
hw/rtl/pab_parse.sv
hw/rtl/pab_outq.sv
hw/rtl/packet_access_beat_parser.sv
tb/tb_packet_access_beat_parser.sv
